/* hw/rtl/dcf77_pulse_decoder_defines.svh */
// Assertion macros used by the checker file of the DCF77 pulse decoder.
// Depends on nothing; it is included by the checker file.
`ifndef DCF77_PULSE_DECODER_DEFINES_SVH
`define DCF77_PULSE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DCF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DCF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/dcfpd_pkg.sv */
// Package of the DCF77 pulse decoder: payload structs, status and register codes,
// reset values and telegram sizes. Depends on nothing.
`timescale 1ns / 1ps

package dcfpd_pkg;

	// Telegram geometry: bit position TELEGRAM_BITS collects overflow bits.
	localparam int TELEGRAM_BITS = 59;
	localparam int TELEGRAM_W    = TELEGRAM_BITS + 1;
	localparam int COUNT_W       = $clog2(TELEGRAM_W);

	localparam int LIMIT_W = 24;
	localparam int TIME_W  = 32;
	localparam int INDEX_W = 2;

	// Register indexes of the configuration port.
	localparam logic [INDEX_W-1:0] CFG_GLITCH_LIMIT = 2'd0;
	localparam logic [INDEX_W-1:0] CFG_ONE_BIT_LIMIT = 2'd1;
	localparam logic [INDEX_W-1:0] CFG_LONG_PULSE_LIMIT = 2'd2;
	localparam logic [INDEX_W-1:0] CFG_MINUTE_GAP = 2'd3;

	// Reset values of the limits, in microseconds.
	localparam logic [LIMIT_W-1:0] GLITCH_LIMIT_RST     = 24'd50000;
	localparam logic [LIMIT_W-1:0] ONE_BIT_LIMIT_RST    = 24'd150000;
	localparam logic [LIMIT_W-1:0] LONG_PULSE_LIMIT_RST = 24'd250000;
	localparam logic [LIMIT_W-1:0] MINUTE_GAP_RST       = 24'd1500000;

	// Result status codes.
	localparam logic [2:0] ST_GLITCH      = 3'd0;
	localparam logic [2:0] ST_START_NOTED = 3'd1;
	localparam logic [2:0] ST_BIT0        = 3'd2;
	localparam logic [2:0] ST_BIT1        = 3'd3;
	localparam logic [2:0] ST_MINUTE_OK   = 3'd4;
	localparam logic [2:0] ST_BAD_COUNT   = 3'd5;
	localparam logic [2:0] ST_BAD_RESET   = 3'd6;

	// One timestamped edge of the receiver output.
	typedef struct packed {
		logic              pulse_start;
		logic [TIME_W-1:0] timestamp_us;
	} evt_item_t;

	// One decoder result.
	typedef struct packed {
		logic [2:0] status;
		logic [6:0] minute_value;
		logic [5:0] hour_value;
		logic [5:0] day_value;
		logic [4:0] month_value;
		logic [7:0] year_value;
	} res_item_t;

	// Current limit settings handed from the register file to the decoder.
	typedef struct packed {
		logic [LIMIT_W-1:0] glitch_limit_us;
		logic [LIMIT_W-1:0] one_bit_limit_us;
		logic [LIMIT_W-1:0] long_pulse_limit_us;
		logic [LIMIT_W-1:0] minute_gap_us;
	} cfg_t;

endpackage

/* hw/rtl/dcf77_pulse_decoder.sv */
// Top level of the DCF77 pulse decoder: input register, decoder and result register.
// Depends on dcfpd_pkg, dcfpd_cfg_regs and dcfpd_decode.
`timescale 1ns / 1ps

// The decoder takes one timestamped receiver edge per clock cycle while results are
// taken, and returns one result per edge. Each edge passes the input register, where
// it is classified against the telegram state and, unless it is a glitch, that state
// is updated, and then the result register. The input register hands its item on
// whenever the result register is empty or being emptied, so the sustained rate is
// one edge per cycle while results are taken. Limit registers may only be written
// while no edge is in flight; there is no clearing pass after reset.
module dcf77_pulse_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          evt_valid,
	output logic                          evt_ready,
	input  dcfpd_pkg::evt_item_t          evt_data,
	output logic                          res_valid,
	input  logic                          res_ready,
	output dcfpd_pkg::res_item_t          res_data,
	input  logic                          cfg_wr_en,
	input  logic [dcfpd_pkg::INDEX_W-1:0] cfg_index,
	input  logic [dcfpd_pkg::LIMIT_W-1:0] cfg_wdata
);

	dcfpd_pkg::cfg_t      cfg;
	dcfpd_pkg::evt_item_t evt_s1;
	logic                 valid_s1;
	dcfpd_pkg::res_item_t result;
	dcfpd_pkg::res_item_t res_q;
	logic                 res_valid_q;
	logic                 advance;

	// Stage 1 moves on when the result register is free or drains this cycle.
	assign advance   = valid_s1 && (!res_valid_q || res_ready);
	assign evt_ready = !valid_s1 || advance;

	dcfpd_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt_ready) begin
			valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_ready && evt_valid) begin
			evt_s1 <= evt_data;
		end
	end

	dcfpd_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (evt_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

/* hw/rtl/dcfpd_cfg_regs.sv */
// Configuration register file of the DCF77 pulse decoder: the four timing limits.
// Depends on dcfpd_pkg.
`timescale 1ns / 1ps

module dcfpd_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [dcfpd_pkg::INDEX_W-1:0]     cfg_index,
	input  logic [dcfpd_pkg::LIMIT_W-1:0]     cfg_wdata,
	output dcfpd_pkg::cfg_t                   cfg
);

	dcfpd_pkg::cfg_t cfg_q;

	// Register writes, decoded by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.glitch_limit_us     <= dcfpd_pkg::GLITCH_LIMIT_RST;
			cfg_q.one_bit_limit_us    <= dcfpd_pkg::ONE_BIT_LIMIT_RST;
			cfg_q.long_pulse_limit_us <= dcfpd_pkg::LONG_PULSE_LIMIT_RST;
			cfg_q.minute_gap_us       <= dcfpd_pkg::MINUTE_GAP_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				dcfpd_pkg::CFG_GLITCH_LIMIT:     cfg_q.glitch_limit_us     <= cfg_wdata;
				dcfpd_pkg::CFG_ONE_BIT_LIMIT:    cfg_q.one_bit_limit_us    <= cfg_wdata;
				dcfpd_pkg::CFG_LONG_PULSE_LIMIT: cfg_q.long_pulse_limit_us <= cfg_wdata;
				dcfpd_pkg::CFG_MINUTE_GAP:       cfg_q.minute_gap_us       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/dcfpd_decode.sv */
// Edge classifier and telegram state of the DCF77 pulse decoder, with BCD decoding.
// Depends on dcfpd_pkg.
`timescale 1ns / 1ps

module dcfpd_decode (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  dcfpd_pkg::evt_item_t  item,
	input  dcfpd_pkg::cfg_t       cfg,
	output dcfpd_pkg::res_item_t  result
);

	localparam int TW = dcfpd_pkg::TELEGRAM_W;
	localparam int CW = dcfpd_pkg::COUNT_W;
	localparam logic [CW-1:0] FULL_COUNT = CW'(dcfpd_pkg::TELEGRAM_BITS);

	logic [dcfpd_pkg::TIME_W-1:0] last_start_q;
	logic [CW-1:0]                bit_count_q;
	logic [TW-1:0]                telegram_q;

	logic [dcfpd_pkg::TIME_W-1:0] delta;
	logic                         is_glitch;
	logic                         over_gap;
	logic                         over_long;
	logic                         over_one;
	logic                         end_tel;
	logic                         add_bit;
	logic                         bit_val;
	logic [2:0]                   end_status;
	logic [2:0]                   status;
	logic [TW-1:0]                telegram_add;
	logic [CW-1:0]                count_add;

	// Time since the last pulse start, wrapping, and its compares to the limits.
	always_comb begin
		delta     = item.timestamp_us - last_start_q;
		is_glitch = delta < {8'd0, cfg.glitch_limit_us};
		over_gap  = delta > {8'd0, cfg.minute_gap_us};
		over_long = delta > {8'd0, cfg.long_pulse_limit_us};
		over_one  = delta > {8'd0, cfg.one_bit_limit_us};
	end

	// Classification of the edge.
	always_comb begin
		if (!over_gap) begin
			end_status = dcfpd_pkg::ST_BAD_RESET;
		end else if (bit_count_q == FULL_COUNT) begin
			end_status = dcfpd_pkg::ST_MINUTE_OK;
		end else begin
			end_status = dcfpd_pkg::ST_BAD_COUNT;
		end
		end_tel = 1'b0;
		add_bit = 1'b0;
		bit_val = 1'b0;
		if (is_glitch) begin
			status = dcfpd_pkg::ST_GLITCH;
		end else if (item.pulse_start) begin
			end_tel = over_gap;
			status  = over_gap ? end_status : dcfpd_pkg::ST_START_NOTED;
		end else if (over_long) begin
			end_tel = 1'b1;
			status  = end_status;
		end else begin
			add_bit = 1'b1;
			bit_val = over_one;
			status  = over_one ? dcfpd_pkg::ST_BIT1 : dcfpd_pkg::ST_BIT0;
		end
	end

	// Telegram with the new bit ORed in at the current count; the count saturates.
	always_comb begin
		for (int i = 0; i < TW; i++) begin
			telegram_add[i] = telegram_q[i] | (bit_val && (bit_count_q == CW'(i)));
		end
		count_add = (bit_count_q == FULL_COUNT) ? FULL_COUNT : bit_count_q + 1'b1;
	end

	// Telegram state, updated once per transfer that is not a glitch.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_start_q <= '0;
			bit_count_q  <= '0;
			telegram_q   <= '0;
		end else if (fire && !is_glitch) begin
			if (item.pulse_start) begin
				last_start_q <= item.timestamp_us;
			end
			if (end_tel) begin
				bit_count_q <= '0;
				telegram_q  <= '0;
			end else if (add_bit) begin
				bit_count_q <= count_add;
				telegram_q  <= telegram_add;
			end
		end
	end

	// BCD fields of the finished telegram; all zero unless the minute is good.
	always_comb begin
		result        = '0;
		result.status = status;
		if (status == dcfpd_pkg::ST_MINUTE_OK) begin
			result.minute_value = {3'd0, telegram_q[24:21]} + 7'(telegram_q[27:25]) * 7'd10;
			result.hour_value   = {2'd0, telegram_q[32:29]} + 6'(telegram_q[34:33]) * 6'd10;
			result.day_value    = {2'd0, telegram_q[39:36]} + 6'(telegram_q[41:40]) * 6'd10;
			result.month_value  = {1'd0, telegram_q[48:45]} + (telegram_q[49] ? 5'd10 : 5'd0);
			result.year_value   = {4'd0, telegram_q[53:50]} + 8'(telegram_q[57:54]) * 8'd10;
		end
	end

endmodule

/* hw/rtl/dcf77_pulse_decoder_checker.sv */
// Port-level checker of the DCF77 pulse decoder and its bind to the top level.
// Depends on dcfpd_pkg and dcf77_pulse_decoder_defines.svh.
`timescale 1ns / 1ps
`include "dcf77_pulse_decoder_defines.svh"

module dcf77_pulse_decoder_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          evt_valid,
	input logic                          evt_ready,
	input dcfpd_pkg::evt_item_t          evt_data,
	input logic                          res_valid,
	input logic                          res_ready,
	input dcfpd_pkg::res_item_t          res_data,
	input logic                          cfg_wr_en,
	input logic [dcfpd_pkg::INDEX_W-1:0] cfg_index,
	input logic [dcfpd_pkg::LIMIT_W-1:0] cfg_wdata
);

	logic values_zero;

	assign values_zero = (res_data.minute_value == '0) && (res_data.hour_value == '0) &&
		(res_data.day_value == '0) && (res_data.month_value == '0) &&
		(res_data.year_value == '0);

	// A stalled result holds until its transfer.
	`DCF_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_data), "result changed while stalled")

	// With the result register empty the decoder always takes a new edge.
	`DCF_ASSERT_IMPLY(a_ready_when_empty, clk, arst_n, !res_valid, evt_ready, "edge refused with empty result register")

	// A result appears only after the transfer of an edge into the input register.
	`DCF_ASSERT_IMPLY(a_res_latency, clk, arst_n, $rose(res_valid), $past(evt_valid && evt_ready, 2), "result without a preceding edge transfer")

	// Decoded time fields are zero unless the minute was received intact.
	`DCF_ASSERT_IMPLY(a_values_gated, clk, arst_n, res_valid && (res_data.status != dcfpd_pkg::ST_MINUTE_OK), values_zero, "time fields set without a good minute")

endmodule

bind dcf77_pulse_decoder dcf77_pulse_decoder_checker u_checker (.*);
